FILE: rtl/core/bcr_pkg.sv
// Shared constants and types for the bilinear channel resize core.
`timescale 1ns / 1ps
package bcr_pkg;

  localparam logic [8:0]  MAX_SRC_W = 9'd256;
  localparam logic [8:0]  MAX_SRC_H = 9'd256;
  localparam logic [10:0] MAX_DST_W = 11'd1024;
  localparam logic [10:0] MAX_DST_H = 11'd1024;
  localparam logic [2:0]  MAX_CH    = 3'd4;

  localparam int BANKS     = 4;
  localparam int BANK_AW   = 14;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_DST_WIDTH     = 3'd2,
    REG_DST_HEIGHT    = 3'd3,
    REG_CHANNEL_COUNT = 3'd4,
    REG_CHANNEL_INDEX = 3'd5
  } reg_idx_t;

  typedef logic [BANK_AW-1:0] bank_addr_t;

  typedef struct packed {
    logic       en;
    logic [1:0] bank;
    bank_addr_t addr;
    logic [7:0] data;
  } mem_wr_t;

endpackage

FILE: rtl/core/bcr_if.sv
// Channel interfaces: request items, result items and register writes.
`timescale 1ns / 1ps
interface bcr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel_in;
  logic [7:0] src_col;
  logic [7:0] src_row;
  logic [9:0] dst_col;
  logic [9:0] dst_row;
  modport source (output valid, opcode, pixel_in, src_col, src_row, dst_col, dst_row,
                  input ready);
  modport sink   (input valid, opcode, pixel_in, src_col, src_row, dst_col, dst_row,
                  output ready);
endinterface

interface bcr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_out;
  logic [21:0] byte_offset;
  modport source (output valid, pixel_out, byte_offset, input ready);
  modport sink   (input valid, pixel_out, byte_offset, output ready);
endinterface

interface bcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bcr_div.sv
// Four-stage restoring divider, two quotient bits per stage, quotient below 256.
`timescale 1ns / 1ps
module bcr_div (
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] dividend,
  input  logic [19:0] divisor,
  output logic [7:0]  quot,
  output logic [19:0] rem
);

  logic [27:0] r   [4];
  logic [7:0]  q   [4];
  logic [19:0] d   [4];
  logic [27:0] r_n [4];
  logic [7:0]  q_n [4];

  always_comb begin
    logic [27:0] rr;
    logic [7:0]  qq;
    logic [27:0] sh;
    for (int k = 0; k < 4; k++) begin
      rr = (k == 0) ? dividend : r[(k == 0) ? 0 : k-1];
      qq = (k == 0) ? 8'd0 : q[(k == 0) ? 0 : k-1];
      for (int j = 0; j < 2; j++) begin
        sh = {8'd0, ((k == 0) ? divisor : d[(k == 0) ? 0 : k-1])} << (7 - 2*k - j);
        if (rr >= sh) begin
          rr = rr - sh;
          qq[7 - 2*k - j] = 1'b1;
        end
      end
      r_n[k] = rr;
      q_n[k] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r[k] <= r_n[k];
        q[k] <= q_n[k];
        d[k] <= (k == 0) ? divisor : d[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign quot = q[3];
  assign rem  = r[3][19:0];

endmodule

FILE: rtl/core/bcr_src_mem.sv
// Source image store: four banks split by row and column parity, registered reads.
`timescale 1ns / 1ps
module bcr_src_mem (
  input  logic                      clk,
  input  logic                      en,
  input  bcr_pkg::mem_wr_t          wr,
  input  bcr_pkg::bank_addr_t [3:0] rd_addr,
  output logic [3:0][7:0]           rd_data
);

  for (genvar b = 0; b < bcr_pkg::BANKS; b++) begin : g_bank
    logic [7:0] ram [bcr_pkg::BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (wr.en && (wr.bank == 2'(b))) begin
        ram[wr.addr] <= wr.data;
      end
      if (en) begin
        rd_data[b] <= ram[rd_addr[b]];
      end
    end
  end

endmodule

FILE: rtl/core/bilinear_channel_resize_core.sv
// Top level of the bilinear channel resize core.
`timescale 1ns / 1ps
// Bilinear resize of one image plane with aligned corners.
// Channels: req takes items; opcode 0 stores pixel_in at (src_row, src_col),
// opcode 1 asks for destination pixel (dst_row, dst_col). rsp returns one item
// per in-range request: pixel_out and its byte_offset in an interleaved buffer.
// Writes and out-of-range requests give no result. cfg writes the six size and
// channel registers, always ready. Users write it only while idle; not enforced.
// Pipeline: 12 register stages, fully pipelined: one item per cycle while the
// pipeline is not stalled. Stages: size checks and coordinate products,
// 4-stage coordinate divider, banked source read (one 2x2 window per cycle
// from four parity banks), two blend multiply stages, 4-stage final divider.
// Writes land in the store at the read stage, so a request behind a write
// sees the new pixel.
// Stall: the whole pipeline holds while a result waits on rsp.ready; req.ready
// drops at the same time, so nothing is lost or repeated.
// Reset clears valid bits and the configuration registers; the source store is
// not cleared and holds garbage until written.
module bilinear_channel_resize_core (
  input logic        clk,
  input logic        rst,
  bcr_in_if.sink     req,
  bcr_out_if.source  rsp,
  bcr_cfg_if.sink    cfg
);

  localparam int NST = 12;

  typedef struct packed {
    logic        op;
    logic        res;     // request inside the destination
    logic        copy;    // sizes equal, straight copy
    logic        lcol;
    logic        lrow;
    logic        direct;  // value taken without blend
    logic [7:0]  pix;
    logic [7:0]  wrow;
    logic [7:0]  wcol;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [19:0] yw;
    logic [21:0] off;
    logic        r0p;
    logic        c0p;
    logic [9:0]  rx;
    logic [9:0]  ry;
    logic [7:0]  dval;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [27:0] bs;      // blend sum into the final divider
    logic [19:0] bd;      // blend divisor
  } item_t;

  // configuration registers
  logic [8:0]  src_width, src_height;
  logic [10:0] dst_width, dst_height;
  logic [2:0]  channel_count;
  logic [1:0]  channel_index;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= 9'd1;
      src_height    <= 9'd1;
      dst_width     <= 11'd1;
      dst_height    <= 11'd1;
      channel_count <= 3'd1;
      channel_index <= 2'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        bcr_pkg::REG_SRC_WIDTH:     src_width     <= cfg.data[8:0];
        bcr_pkg::REG_SRC_HEIGHT:    src_height    <= cfg.data[8:0];
        bcr_pkg::REG_DST_WIDTH:     dst_width     <= cfg.data;
        bcr_pkg::REG_DST_HEIGHT:    dst_height    <= cfg.data;
        bcr_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data[2:0];
        bcr_pkg::REG_CHANNEL_INDEX: channel_index <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes; config must stay static while items are in flight (not enforced)
  logic [8:0]  lw, lh, lw_m1, lh_m1;
  logic [10:0] w, h, w_m1, h_m1;
  logic [2:0]  ch, ch_m1;
  logic [1:0]  ci;
  logic [9:0]  dx, dy;

  always_comb begin
    lw = (src_width == 9'd0) ? 9'd1 :
         (src_width > bcr_pkg::MAX_SRC_W) ? bcr_pkg::MAX_SRC_W : src_width;
    lh = (src_height == 9'd0) ? 9'd1 :
         (src_height > bcr_pkg::MAX_SRC_H) ? bcr_pkg::MAX_SRC_H : src_height;
    w  = (dst_width == 11'd0) ? 11'd1 :
         (dst_width > bcr_pkg::MAX_DST_W) ? bcr_pkg::MAX_DST_W : dst_width;
    h  = (dst_height == 11'd0) ? 11'd1 :
         (dst_height > bcr_pkg::MAX_DST_H) ? bcr_pkg::MAX_DST_H : dst_height;
    ch = (channel_count == 3'd0) ? 3'd1 :
         (channel_count > bcr_pkg::MAX_CH) ? bcr_pkg::MAX_CH : channel_count;
    lw_m1 = lw - 9'd1;
    lh_m1 = lh - 9'd1;
    w_m1  = w - 11'd1;
    h_m1  = h - 11'd1;
    ch_m1 = ch - 3'd1;
    ci    = ({1'b0, channel_index} >= ch) ? ch_m1[1:0] : channel_index;
    dx    = w_m1[9:0];
    dy    = h_m1[9:0];
  end

  item_t sb    [NST];
  item_t sb_nx [NST];
  logic  vld   [NST];
  logic  adv;

  logic [7:0]  qx, qy, qb;
  logic [19:0] rxf, ryf, rbf;

  bcr_pkg::mem_wr_t          mwr;
  bcr_pkg::bank_addr_t [3:0] mrd_addr;
  logic [3:0][7:0]           mrd_data;

  assign adv       = !(vld[NST-1] && sb[NST-1].res) || rsp.ready;
  assign req.ready = adv;

  always_comb begin
    logic [7:0] row0, col0, row1, col1, rsel, csel, ly;
    logic [7:0] p00, p01, p10, p11;
    logic [1:0] b;

    // stage A: range checks and coordinate products
    sb_nx[0]        = sb[0];
    sb_nx[0].op     = req.opcode;
    sb_nx[0].res    = (req.opcode == bcr_pkg::OP_REQUEST) &&
                      ({1'b0, req.dst_col} < w) && ({1'b0, req.dst_row} < h);
    sb_nx[0].copy   = ({2'b0, lw} == w) && ({2'b0, lh} == h);
    sb_nx[0].lcol   = ({1'b0, req.dst_col} == w_m1);
    sb_nx[0].lrow   = ({1'b0, req.dst_row} == h_m1);
    sb_nx[0].direct = sb_nx[0].copy || sb_nx[0].lcol;
    sb_nx[0].pix    = req.pixel_in;
    sb_nx[0].wrow   = req.src_row;
    sb_nx[0].wcol   = req.src_col;
    sb_nx[0].x      = req.dst_col;
    sb_nx[0].y      = req.dst_row;
    sb_nx[0].nx     = {8'd0, req.dst_col} * {10'd0, lw_m1[7:0]};
    sb_nx[0].ny     = {8'd0, req.dst_row} * {10'd0, lh_m1[7:0]};
    sb_nx[0].yw     = {10'd0, req.dst_row} * {9'd0, w};

    for (int k = 1; k < NST; k++) begin
      sb_nx[k] = sb[k-1];
    end

    // stages B, C: byte offset
    sb_nx[1].off = {2'd0, sb[0].yw + {10'd0, sb[0].x}};
    sb_nx[2].off = (sb[1].off * {19'd0, ch}) + {20'd0, ci};

    // stage E: window position and bank addresses
    ly   = sb[4].lrow ? lh_m1[7:0] : qy;
    if (sb[4].copy) begin
      row0 = sb[4].y[7:0];
      col0 = sb[4].x[7:0];
    end else if (sb[4].lcol) begin
      row0 = ly;
      col0 = lw_m1[7:0];
    end else begin
      row0 = ly;
      col0 = qx;
    end
    row1 = row0 + 8'd1;  // wraps only where the lower row is unused
    col1 = col0 + 8'd1;
    for (int k = 0; k < 4; k++) begin
      b    = 2'(k);
      rsel = (row0[0] == b[1]) ? row0 : row1;
      csel = (col0[0] == b[0]) ? col0 : col1;
      mrd_addr[k] = {rsel[7:1], csel[7:1]};
    end
    sb_nx[5].r0p = row0[0];
    sb_nx[5].c0p = col0[0];
    sb_nx[5].rx  = rxf[9:0];
    sb_nx[5].ry  = ryf[9:0];

    mwr.en   = adv && vld[4] && (sb[4].op == bcr_pkg::OP_WRITE);
    mwr.bank = {sb[4].wrow[0], sb[4].wcol[0]};
    mwr.addr = {sb[4].wrow[7:1], sb[4].wcol[7:1]};
    mwr.data = sb[4].pix;

    // stage F: horizontal blends of both rows
    p00 = mrd_data[{sb[5].r0p,  sb[5].c0p}];
    p01 = mrd_data[{sb[5].r0p, !sb[5].c0p}];
    p10 = mrd_data[{!sb[5].r0p,  sb[5].c0p}];
    p11 = mrd_data[{!sb[5].r0p, !sb[5].c0p}];
    sb_nx[6].dval = p00;
    sb_nx[6].lo   = ({10'd0, p00} * {8'd0, dx - sb[5].rx}) + ({10'd0, p01} * {8'd0, sb[5].rx});
    sb_nx[6].hi   = ({10'd0, p10} * {8'd0, dx - sb[5].rx}) + ({10'd0, p11} * {8'd0, sb[5].rx});

    // stage G: vertical blend, registered ahead of the final divider
    if (sb[6].lrow) begin
      sb_nx[7].bs = {10'd0, sb[6].lo};
      sb_nx[7].bd = {10'd0, dx};
    end else begin
      sb_nx[7].bs = ({10'd0, sb[6].lo} * {18'd0, dy - sb[6].ry}) +
                    ({10'd0, sb[6].hi} * {18'd0, sb[6].ry});
      sb_nx[7].bd = {10'd0, dx} * {10'd0, dy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= req.valid;
      for (int k = 1; k < NST; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) sb[k] <= sb_nx[k];
    end
  end

  bcr_div u_div_x (
    .clk      (clk),
    .en       (adv),
    .dividend ({10'd0, sb[0].nx}),
    .divisor  ({10'd0, dx}),
    .quot     (qx),
    .rem      (rxf)
  );

  bcr_div u_div_y (
    .clk      (clk),
    .en       (adv),
    .dividend ({10'd0, sb[0].ny}),
    .divisor  ({10'd0, dy}),
    .quot     (qy),
    .rem      (ryf)
  );

  bcr_src_mem u_mem (
    .clk     (clk),
    .en      (adv),
    .wr      (mwr),
    .rd_addr (mrd_addr),
    .rd_data (mrd_data)
  );

  // remainder of the final division is not needed
  bcr_div u_div_blend (
    .clk      (clk),
    .en       (adv),
    .dividend (sb[7].bs),
    .divisor  (sb[7].bd),
    .quot     (qb),
    .rem      (rbf)
  );

  assign rsp.valid       = vld[NST-1] && sb[NST-1].res;
  assign rsp.pixel_out   = sb[NST-1].direct ? sb[NST-1].dval : qb;
  assign rsp.byte_offset = sb[NST-1].off | {2'd0, rbf & 20'd0};

endmodule

FILE: tb/sv/bcr_resize_checker.sv
// Checker for the resize core: mirrors the source store, predicts results, compares.
`timescale 1ns / 1ps
module bcr_resize_checker
  import bcr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bcr_in_if    req,
  bcr_out_if   rsp,
  bcr_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic [7:0]  pixel;
    logic [21:0] offset;
  } dst_pixel_t;

  logic [7:0]  plane [0:65535];
  logic [8:0]  src_w_reg, src_h_reg;
  logic [10:0] dst_w_reg, dst_h_reg;
  logic [2:0]  ch_cnt_reg;
  logic [1:0]  ch_idx_reg;
  dst_pixel_t  expected_pixels[$];
  int          mismatches;

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned src_px(longint unsigned row, longint unsigned col);
    if (row > 255) row = 255;
    if (col > 255) col = 255;
    return plane[row * 256 + col];
  endfunction

  // Bilinear value with aligned corners; edge rows and columns follow the edge rules.
  function automatic dst_pixel_t predict_pixel(longint unsigned x, longint unsigned y);
    longint unsigned lw, lh, w, h, ch, ci, dx, lx, rx, dy, ly, ry, lo, hi, s, val;
    dst_pixel_t r;
    lw = clamp(src_w_reg, MAX_SRC_W);
    lh = clamp(src_h_reg, MAX_SRC_H);
    w  = clamp(dst_w_reg, MAX_DST_W);
    h  = clamp(dst_h_reg, MAX_DST_H);
    ch = clamp(ch_cnt_reg, MAX_CH);
    ci = (ch_idx_reg >= ch) ? ch - 1 : ch_idx_reg;
    if (lw == w && lh == h) begin
      val = src_px(y, x);
    end else begin
      dx = 0; lx = lw - 1; rx = 0;
      dy = 0; ly = lh - 1; ry = 0;
      if (x != w - 1) begin
        dx = w - 1;
        lx = x * (lw - 1) / dx;
        rx = x * (lw - 1) % dx;
      end
      if (y != h - 1) begin
        dy = h - 1;
        ly = y * (lh - 1) / dy;
        ry = y * (lh - 1) % dy;
      end
      if (x == w - 1) begin
        val = src_px(ly, lw - 1);
      end else if (y == h - 1) begin
        s = src_px(ly, lx) * (dx - rx) + src_px(ly, lx + 1) * rx;
        val = s / dx;
      end else begin
        lo = src_px(ly, lx) * (dx - rx) + src_px(ly, lx + 1) * rx;
        hi = src_px(ly + 1, lx) * (dx - rx) + src_px(ly + 1, lx + 1) * rx;
        s = lo * (dy - ry) + hi * ry;
        val = s / (dx * dy);
      end
    end
    r.pixel  = val[7:0];
    r.offset = 22'(((y * w + x) * ch + ci));
    return r;
  endfunction

  always @(posedge clk) begin
    dst_pixel_t e;
    if (rst) begin
      src_w_reg  <= 9'd1;
      src_h_reg  <= 9'd1;
      dst_w_reg  <= 11'd1;
      dst_h_reg  <= 11'd1;
      ch_cnt_reg <= 3'd1;
      ch_idx_reg <= 2'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_SRC_WIDTH:     src_w_reg  <= cfg.data[8:0];
          REG_SRC_HEIGHT:    src_h_reg  <= cfg.data[8:0];
          REG_DST_WIDTH:     dst_w_reg  <= cfg.data;
          REG_DST_HEIGHT:    dst_h_reg  <= cfg.data;
          REG_CHANNEL_COUNT: ch_cnt_reg <= cfg.data[2:0];
          REG_CHANNEL_INDEX: ch_idx_reg <= cfg.data[1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.opcode == OP_WRITE) begin
          plane[{req.src_row, req.src_col}] = req.pixel_in;
        end else if (req.dst_col < clamp(dst_w_reg, MAX_DST_W) &&
                     req.dst_row < clamp(dst_h_reg, MAX_DST_H)) begin
          expected_pixels.push_back(predict_pixel(req.dst_col, req.dst_row));
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result pixel=%0d offset=%0d", $realtime,
                     rsp.pixel_out, rsp.byte_offset);
        end else begin
          e = expected_pixels.pop_front();
          if (rsp.pixel_out !== e.pixel || rsp.byte_offset !== e.offset) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result differs: pixel exp %0d got %0d, offset exp %0d got %0d",
                       $realtime, e.pixel, rsp.pixel_out, e.offset, rsp.byte_offset);
          end
        end
      end
    end
    pending = expected_pixels.size();
    errors  = mismatches;
  end

  initial begin
    mismatches = 0;
    errors = 0;
    pending = 0;
  end

endmodule

FILE: tb/sv/bilinear_channel_resize_core_tb.sv
// Testbench top for the bilinear channel resize core: stimulus, flow control, verdict.
`timescale 1ns / 1ps
module bilinear_channel_resize_core_tb;
  import bcr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcr_in_if  req ();
  bcr_out_if rsp ();
  bcr_cfg_if cfg ();

  int errors, pending;

  // flow-control knobs, percent of cycles spent idle / stalled
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int phase_no = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  localparam int HOLD_PHASE = 9;   // phase where the receiver backs off for a long stretch

  // effective sizes of the current phase, used to seed the source plane
  int eff_sw, eff_sh, eff_dw, eff_dh;

  always #5 clk = ~clk;

  bilinear_channel_resize_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  bcr_resize_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_WRITE;
    req.pixel_in = '0;
    req.src_col = '0;
    req.src_row = '0;
    req.dst_col = '0;
    req.dst_row = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rsp.ready = 1'b0;
  end

  // Result-side back-pressure; one long hold in the hold phase fills the pipe.
  always @(negedge clk) begin
    if (phase_no == HOLD_PHASE && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // One item on req; valid stays high between back-to-back items.
  task automatic send_item(logic op, logic [7:0] pix, logic [7:0] scol, logic [7:0] srow,
                           logic [9:0] dcol, logic [9:0] drow);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.pixel_in <= pix;
    req.src_col  <= scol;
    req.src_row  <= srow;
    req.dst_col  <= dcol;
    req.dst_row  <= drow;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Leaves valid high so register writes can follow back to back.
  task automatic write_reg(reg_idx_t idx, logic [10:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  function automatic int sat_size(int raw, int hi);
    return (raw < 1) ? 1 : (raw > hi) ? hi : raw;
  endfunction

  // Drain the pipe, then reprogram every register and reseed the plane.
  task automatic configure(int sw, int sh, int dw, int dh, int cc, int ci);
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (15) @(negedge clk);   // writes in flight give no result, let them land
    write_reg(REG_SRC_WIDTH, 11'(sw));
    write_reg(REG_SRC_HEIGHT, 11'(sh));
    write_reg(REG_DST_WIDTH, 11'(dw));
    write_reg(REG_DST_HEIGHT, 11'(dh));
    write_reg(REG_CHANNEL_COUNT, 11'(cc));
    write_reg(REG_CHANNEL_INDEX, 11'(ci));
    cfg.valid <= 1'b0;
    eff_sw = sat_size(sw & 9'h1FF, 256);
    eff_sh = sat_size(sh & 9'h1FF, 256);
    eff_dw = sat_size(dw & 11'h7FF, 1024);
    eff_dh = sat_size(dh & 11'h7FF, 1024);
    seed_plane();
  endtask

  // Every source pixel that a request can weight lies inside the image.
  task automatic seed_plane();
    for (int r = 0; r < eff_sh; r++)
      for (int c = 0; c < eff_sw; c++)
        send_item(OP_WRITE, 8'($urandom), 8'(c), 8'(r), 10'($urandom), 10'($urandom));
  endtask

  function automatic int pick_coord(int n);
    case ($urandom_range(5))
      0: return 0;
      1: return n - 1;
      default: return $urandom_range(n - 1);
    endcase
  endfunction

  // Mostly in-range requests, some plane updates, a few requests off the image.
  task automatic run_traffic(int count);
    int rows, cols;
    rows = (eff_sh < 256) ? eff_sh + 1 : 256;
    cols = (eff_sw < 256) ? eff_sw + 1 : 256;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1:
          send_item(OP_WRITE, 8'($urandom), 8'($urandom_range(cols - 1)),
                    8'($urandom_range(rows - 1)), 10'($urandom), 10'($urandom));
        2:
          send_item(OP_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom),
                    10'($urandom), 10'($urandom));
        default:
          send_item(OP_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom),
                    10'(pick_coord(eff_dw)), 10'(pick_coord(eff_dh)));
      endcase
    end
  endtask

  task automatic corner_requests();
    send_item(OP_REQUEST, 8'hFF, 8'hFF, 8'hFF, 10'd0, 10'd0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 8'h00, 10'(eff_dw - 1), 10'd0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 8'h00, 10'd0, 10'(eff_dh - 1));
    send_item(OP_REQUEST, 8'h00, 8'h00, 8'h00, 10'(eff_dw - 1), 10'(eff_dh - 1));
    send_item(OP_REQUEST, 8'h00, 8'h00, 8'h00, 10'h3FF, 10'h3FF);
  endtask

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: one-pixel copy, then requests past the one-pixel image.
    eff_sw = 1; eff_sh = 1; eff_dw = 1; eff_dh = 1;
    seed_plane();
    corner_requests();
    send_item(OP_REQUEST, 8'h00, 8'h00, 8'h00, 10'd1, 10'd0);
    send_item(OP_REQUEST, 8'h00, 8'h00, 8'h00, 10'd0, 10'd1);

    // Directed settings: copy, resize, size-one destination, widest, tallest,
    // out-of-range registers with saturation, channel index past the count.
    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: configure(4, 3, 4, 3, 1, 0);
        2: configure(4, 3, 7, 5, 3, 2);
        3: configure(2, 2, 1, 1, 4, 3);
        4: configure(256, 1, 1024, 3, 4, 3);
        5: configure(1, 256, 2, 1024, 2, 1);
        6: configure(0, 3, 2047, 0, 7, 3);
        default: configure(5, 5, 5, 5, 0, 2);
      endcase
      corner_requests();
      run_traffic(12);
    end

    // Random settings, cycling the flow-control modes.
    for (int p = 8; p < 20; p++) begin
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 86 : (mode == 3) ? 26 : 0;
      rsp_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 26 : 0;
      if ($urandom_range(4) == 0)
        configure($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                  $urandom_range(1, 16), $urandom_range(0, 7), $urandom_range(0, 3));
      else
        configure($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 40),
                  $urandom_range(1, 40), $urandom_range(1, 4), $urandom_range(0, 3));
      if (p == HOLD_PHASE) begin
        send_idle_pct = 0;
        rsp_stall_pct = 0;
      end
      phase_no = p;
      run_traffic(28);
    end

    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
